>>> src/piecewise_linear_branch_predictor_macros.svh
// assertion helpers for the branch predictor
`ifndef PIECEWISE_LINEAR_BRANCH_PREDICTOR_MACROS_SVH
`define PIECEWISE_LINEAR_BRANCH_PREDICTOR_MACROS_SVH

// same-cycle implication
`define PLBP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PLBP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/plbp_pkg.sv
`default_nettype none
package plbp_pkg;
   localparam int ADDR_BITS_DEF   = 4;
   localparam int HIST_LEN_DEF    = 8;
   localparam int WEIGHT_BITS_DEF = 8;
   localparam int THETA_BITS      = 11;
   localparam logic [THETA_BITS-1:0] THETA_RESET = 11'd39;
   localparam int SHOWN_BITS      = 12;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LAST,
      ST_DECIDE,
      ST_WRITE
   } state_type;
endpackage
`default_nettype wire

>>> src/piecewise_linear_branch_predictor.sv
// flow: an accepted request reads its path weights in ST_READ, passes ST_LAST, and in
// ST_DECIDE registers its response, training or not; in training, the HIST_LEN weight writes
// of ST_WRITE follow the response; a stalled response holds the decide step; a new request is
// taken only in ST_IDLE. reset: synchronous, clears histories, bias weights and control, then
// a clearing pass zeroes the 2^(2*ADDR_BITS + clog2(HIST_LEN)) path weights while no request
// is taken; threshold resets to 39
`default_nettype none
`include "piecewise_linear_branch_predictor_macros.svh"
module piecewise_linear_branch_predictor
   import plbp_pkg::*;
#(
   parameter int ADDR_BITS   = ADDR_BITS_DEF,
   parameter int HIST_LEN    = HIST_LEN_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [31:0] branch_address, [32] actual_taken, [39:33] zero
   input  wire logic [39:0]           req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] predict_taken, [12:1] weight_sum, [15:13] zero
   output logic [15:0]                rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [THETA_BITS-1:0] csr_wdata
);
   localparam int IB     = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
   localparam int CNT_W  = $clog2(HIST_LEN + 1);
   localparam int MEM_AW = 2 * ADDR_BITS + IB;
   localparam int N_ADDR = 1 << ADDR_BITS;
   localparam int SUM_BITS = WEIGHT_BITS + $clog2(HIST_LEN + 1) + 1;
   localparam int CW = ((SUM_BITS + 1) > (THETA_BITS + 1)) ? (SUM_BITS + 1) : (THETA_BITS + 1);
   localparam logic signed [CW-1:0] SAT_HI = CW'(2047);
   localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - CW'(1);
   localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
   localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(HIST_LEN - 1);

   state_type state_ff, state_in;

   // weight memory
   logic signed [WEIGHT_BITS-1:0] mem [2**MEM_AW];
   logic signed [WEIGHT_BITS-1:0] rdata_ff;
   logic [MEM_AW-1:0]             raddr, waddr;
   logic                          we;
   logic signed [WEIGHT_BITS-1:0] wdata;

   logic [THETA_BITS-1:0]         theta_ff;
   logic [HIST_LEN-1:0]           hist_ff, hist_in;
   logic [ADDR_BITS-1:0]          ahist_ff [HIST_LEN];
   logic [ADDR_BITS-1:0]          ahist_in [HIST_LEN];
   logic signed [WEIGHT_BITS-1:0] bias_ff [N_ADDR];
   logic signed [WEIGHT_BITS-1:0] wbuf_ff [HIST_LEN];

   logic [ADDR_BITS-1:0]  a_ff;
   logic                  taken_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rvld_ff, rvld_in;
   logic [IB-1:0]         ridx_ff;
   logic [MEM_AW-1:0]     clr_ff;
   logic signed [SUM_BITS-1:0] acc_ff;

   logic                  rsp_valid_ff;
   logic [15:0]           rsp_data_ff;

   logic                  accept, out_free, load_out, train, finish, bias_upd;
   logic signed [CW-1:0]  acc_x, mag, shown;
   logic                  pred;
   logic signed [WEIGHT_BITS-1:0] bias_new, wold;
   logic                  up;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // sum derived values
   always_comb begin
      acc_x = CW'(acc_ff);
      pred  = !acc_ff[SUM_BITS-1];
      mag   = pred ? acc_x : -acc_x;
      train = (mag < $signed({{(CW-THETA_BITS){1'b0}}, theta_ff})) || (pred != taken_ff);
      if (acc_x > SAT_HI) shown = SAT_HI;
      else if (acc_x < SAT_LO) shown = SAT_LO;
      else shown = acc_x;
      if (taken_ff) bias_new = (bias_ff[a_ff] < W_MAX) ? bias_ff[a_ff] + 1'b1 : W_MAX;
      else bias_new = (bias_ff[a_ff] > W_MIN) ? bias_ff[a_ff] - 1'b1 : W_MIN;
   end

   // training write data
   always_comb begin
      wold = wbuf_ff[cnt_ff[IB-1:0]];
      up   = (hist_ff[cnt_ff[IB-1:0]] == taken_ff);
      if (up) wdata = (wold < W_MAX) ? wold + 1'b1 : W_MAX;
      else wdata = (wold > W_MIN) ? wold - 1'b1 : W_MIN;
   end

   assign raddr = {a_ff, ahist_ff[cnt_ff[IB-1:0]], cnt_ff[IB-1:0]};

   // next state and control
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rvld_in  = 1'b0;
      we       = 1'b0;
      waddr    = clr_ff;
      load_out = 1'b0;
      finish   = 1'b0;
      bias_upd = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            we = 1'b1;
            if (&clr_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_READ;
               cnt_in   = '0;
            end
         end
         ST_READ: begin
            rvld_in = 1'b1;
            if (cnt_ff == LAST_IDX) state_in = ST_LAST;
            else cnt_in = cnt_ff + 1'b1;
         end
         ST_LAST: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (out_free) begin
               load_out = 1'b1;
               if (train) begin
                  bias_upd = 1'b1;
                  cnt_in   = '0;
                  state_in = ST_WRITE;
               end else begin
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WRITE: begin
            we    = 1'b1;
            waddr = {a_ff, ahist_ff[cnt_ff[IB-1:0]], cnt_ff[IB-1:0]};
            if (cnt_ff == LAST_IDX) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end else cnt_in = cnt_ff + 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // history shift
   always_comb begin
      hist_in = hist_ff;
      for (int i = 0; i < HIST_LEN; i++) ahist_in[i] = ahist_ff[i];
      if (finish) begin
         for (int i = HIST_LEN - 1; i > 0; i--) begin
            hist_in[i]  = hist_ff[i-1];
            ahist_in[i] = ahist_ff[i-1];
         end
         hist_in[0]  = taken_ff;
         ahist_in[0] = a_ff;
      end
   end

   // memory port
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= (state_ff == ST_CLEAR) ? '0 : wdata;
      rdata_ff <= mem[raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         theta_ff     <= THETA_RESET;
         hist_ff      <= '0;
         for (int i = 0; i < HIST_LEN; i++) ahist_ff[i] <= '0;
         for (int i = 0; i < N_ADDR; i++) bias_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rvld_ff  <= rvld_in;
         hist_ff  <= hist_in;
         for (int i = 0; i < HIST_LEN; i++) ahist_ff[i] <= ahist_in[i];
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_we) theta_ff <= csr_wdata;
         if (bias_upd) bias_ff[a_ff] <= bias_new;
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // request capture, accumulation and result
   always_ff @(posedge clock) begin
      ridx_ff <= cnt_ff[IB-1:0];
      if (accept) begin
         a_ff     <= req_tdata[ADDR_BITS-1:0];
         taken_ff <= req_tdata[32];
         acc_ff   <= SUM_BITS'(bias_ff[req_tdata[ADDR_BITS-1:0]]);
      end else if (rvld_ff) begin
         wbuf_ff[ridx_ff] <= rdata_ff;
         if (hist_ff[ridx_ff]) acc_ff <= acc_ff + SUM_BITS'(rdata_ff);
         else acc_ff <= acc_ff - SUM_BITS'(rdata_ff);
      end
      if (load_out) rsp_data_ff <= {3'b000, shown[SHOWN_BITS-1:0], pred};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `PLBP_ASSERT_NOW(a_no_req_clear, state_ff == ST_CLEAR, !req_tready,
      "request taken during clearing pass")
   `PLBP_ASSERT_NOW(a_sign_match, rsp_tvalid, rsp_tdata[0] == !rsp_tdata[12],
      "prediction disagrees with sum sign")
   `PLBP_ASSERT_NEXT(a_accept_read, accept, state_ff == ST_READ && cnt_ff == '0,
      "accepted request did not start reading")
endmodule
`default_nettype wire

>>> bench/tb_piecewise_linear_branch_predictor.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_piecewise_linear_branch_predictor;
   import plbp_pkg::*;

   localparam int ABITS = ADDR_BITS_DEF;
   localparam int HLEN  = HIST_LEN_DEF;
   localparam int WBITS = WEIGHT_BITS_DEF;
   localparam int NADDR = 1 << ABITS;
   localparam int WMAX  = (1 << (WBITS - 1)) - 1;
   localparam int WMIN  = -(1 << (WBITS - 1));
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic        actual_taken;
      logic [31:0] branch_address;
   } branch_t;

   typedef struct packed {
      logic [11:0] weight_sum;
      logic        predict_taken;
   } verdict_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [THETA_BITS-1:0] csr_wdata = '0;

   piecewise_linear_branch_predictor u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // predictor state
   int            path_w [NADDR][NADDR][HLEN];
   int            bias_w [NADDR];
   logic [HLEN-1:0] outcome_hist;
   logic [ABITS-1:0] addr_hist [HLEN];
   int            theta;

   branch_t  branch_queue[$];
   verdict_t verdict_queue[$];
   int       mismatches = 0;
   int       cycles = 0;
   bit       timed_out = 0;
   bit       gaps_on = 1;

   initial forever #5 clock = ~clock;

   function automatic int nudge_weight(int w, bit up);
      if (up) return (w < WMAX) ? w + 1 : WMAX;
      return (w > WMIN) ? w - 1 : WMIN;
   endfunction

   // compute verdict, train if needed and shift the histories, as the block does on one request
   function automatic verdict_t predict_branch(branch_t b);
      logic [ABITS-1:0] a;
      int sum, mag, shown;
      bit pred, tk;
      verdict_t v;
      a = b.branch_address[ABITS-1:0];
      tk = b.actual_taken;
      sum = bias_w[a];
      for (int i = 0; i < HLEN; i++)
         sum += outcome_hist[i] ? path_w[a][addr_hist[i]][i] : -path_w[a][addr_hist[i]][i];
      pred = sum >= 0;
      shown = sum > 2047 ? 2047 : (sum < -2048 ? -2048 : sum);
      v.predict_taken = pred;
      v.weight_sum = shown[11:0];
      mag = sum < 0 ? -sum : sum;
      if (mag < theta || pred != tk) begin
         bias_w[a] = nudge_weight(bias_w[a], tk);
         for (int i = 0; i < HLEN; i++)
            path_w[a][addr_hist[i]][i] =
               nudge_weight(path_w[a][addr_hist[i]][i], outcome_hist[i] == tk);
      end
      for (int i = HLEN - 1; i > 0; i--) addr_hist[i] = addr_hist[i-1];
      addr_hist[0] = a;
      outcome_hist = {outcome_hist[HLEN-2:0], tk};
      return v;
   endfunction

   // request driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            verdict_queue.push_back(predict_branch(branch_queue.pop_front()));
            send_gap <= gaps_on ? $urandom_range(0, 19) : 0;
            if (branch_queue.size() > 0 && !(gaps_on && $urandom_range(0, 1))) begin
               req_tdata <= {7'd0, branch_queue[0]};
            end else begin
               req_tvalid <= 1'b0;
            end
         end else if (!req_tvalid) begin
            if (send_gap > 0) send_gap <= send_gap - 1;
            else if (branch_queue.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= {7'd0, branch_queue[0]};
            end
         end
      end
   end

   // response monitor with random stall
   int stall = 0;
   always @(posedge clock) begin
      verdict_t got, want;
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[12:0];
            if (verdict_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
            end else begin
               want = verdict_queue.pop_front();
               if (got !== want || rsp_tdata[15:13] !== 3'b000) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected taken=%0b sum=%0d, got taken=%0b sum=%0d",
                        want.predict_taken, $signed(want.weight_sum),
                        got.predict_taken, $signed(got.weight_sum));
               end
            end
            stall = gaps_on ? $urandom_range(0, 19) : 0;
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // timeout watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("** piecewise_linear_branch_predictor: FAILED **");
         $finish;
      end
   end

   function automatic branch_t make_branch(logic [31:0] addr, bit tk);
      branch_t b;
      b.branch_address = addr;
      b.actual_taken = tk;
      return b;
   endfunction

   task automatic drain();
      wait (branch_queue.size() == 0 && !req_tvalid);
      wait (verdict_queue.size() == 0);
      repeat (3 * HLEN + 10) @(posedge clock);
   endtask

   task automatic write_theta(int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value[THETA_BITS-1:0];
      theta = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // a loop of branch patterns with random content
   task automatic queue_random(int count);
      logic [3:0] loop_pcs [4];
      bit loop_dir [4];
      for (int k = 0; k < 4; k++) begin
         loop_pcs[k] = 4'($urandom);
         loop_dir[k] = 1'($urandom_range(0, 1));
      end
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0)
            branch_queue.push_back(make_branch($urandom, 1'($urandom_range(0, 1))));
         else begin
            int k = n % 4;
            branch_queue.push_back(make_branch(
               {28'($urandom_range(0, 32'hFFF_FFFF)), loop_pcs[k]},
               (n % 7 == 6) ? !loop_dir[k] : loop_dir[k]));
         end
      end
   endtask

   initial begin
      foreach (bias_w[a]) bias_w[a] = 0;
      foreach (path_w[a, p, i]) path_w[a][p][i] = 0;
      foreach (addr_hist[i]) addr_hist[i] = '0;
      outcome_hist = '0;
      theta = THETA_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: address extremes, both outcomes, training bursts
      branch_queue.push_back(make_branch(32'h0000_0000, 1'b0));
      branch_queue.push_back(make_branch(32'hFFFF_FFFF, 1'b1));
      branch_queue.push_back(make_branch(32'hAAAA_AAA5, 1'b1));
      branch_queue.push_back(make_branch(32'h5555_555A, 1'b0));
      for (int n = 0; n < 16; n++)
         branch_queue.push_back(make_branch(32'h8000_0003, 1'b1));
      drain();

      // zero threshold trains only on mispredictions
      write_theta(0);
      queue_random(150);
      drain();
      // maximum threshold keeps saturating the weights
      write_theta(2047);
      gaps_on = 0;
      for (int n = 0; n < 200; n++) branch_queue.push_back(make_branch(32'h0000_0007, 1'b1));
      for (int n = 0; n < 200; n++) branch_queue.push_back(make_branch(32'h0000_0007, 1'b0));
      drain();
      gaps_on = 1;
      write_theta(1152);
      queue_random(200);
      drain();
      write_theta(THETA_RESET);
      queue_random(250);
      drain();
      write_theta($urandom_range(1, 60));
      queue_random(130);
      drain();

      if (mismatches == 0 && verdict_queue.size() == 0)
         $display("** piecewise_linear_branch_predictor: PASSED **");
      else
         $display("** piecewise_linear_branch_predictor: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
